[hdl/cfe_pkg.sv]
// Package for the CRC16 / COBS frame encoder: widths, codes, record types
// and the CRC and COBS step functions. Depends on nothing.
`timescale 1ns / 1ps

package cfe_pkg;

  // Field widths
  localparam int BYTE_W = 8;
  localparam int WORD_W = 16;
  localparam int POS_W  = WORD_W + 1;
  localparam int CFG_IDX_W = 1;

  typedef logic [BYTE_W-1:0]    byte_t;
  typedef logic [WORD_W-1:0]    word_t;
  typedef logic [POS_W-1:0]     pos_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Defaults for the top-level parameters
  localparam int ADDR_WIDTH_DEF  = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Constants of the framing
  localparam word_t CRC_INIT    = 16'hFFFF;
  localparam word_t CRC_POLY    = 16'h1021;
  localparam byte_t FULL_CODE   = 8'hFF;
  localparam byte_t DELIM       = 8'h00;
  localparam word_t CAP_RESET   = 16'hFFFF;
  localparam word_t LIMIT_RESET = 16'd18000;

  // Configuration register indexes
  localparam cfg_idx_t REG_OUT_CAPACITY  = 1'd0;
  localparam cfg_idx_t REG_PAYLOAD_LIMIT = 1'd1;

  // Front sequencer: payload bytes, then the CRC tail and the close step
  typedef enum logic [1:0] {
    ST_PAYLOAD,
    ST_CRC_LO,
    ST_CRC_HI,
    ST_CLOSE
  } front_state_t;

  // One result item
  typedef struct packed {
    logic  write_en;
    word_t out_addr;
    byte_t out_value;
    logic  frame_end;
    logic  frame_ok;
    word_t frame_length;
  } result_t;

  // One queue record: one or two results of a front step
  typedef struct packed {
    result_t a;
    result_t b;
    logic    two;
    logic    step_end;
  } rec_t;

  // Outcome of feeding one byte to the COBS writer
  typedef struct packed {
    logic       failed;
    pos_t       wp;
    word_t      cp;
    byte_t      gc;
    logic [1:0] n_wr;
    word_t      a_addr;
    byte_t      a_val;
    word_t      b_addr;
  } cobs_t;

  // CRC16-CCITT over one byte, MSB first
  function automatic word_t crc_byte(input word_t crc, input byte_t b);
    word_t c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < BYTE_W; i++) begin
      if (c[WORD_W-1]) begin
        c = {c[WORD_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[WORD_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

  // Feed one byte to the COBS writer: data write, code patch on zero,
  // and a forced code patch when a group of 254 bytes fills up
  function automatic cobs_t cobs_feed(input logic fail, input pos_t wp, input word_t cp,
                                      input byte_t gc, input byte_t b, input word_t cap);
    cobs_t r;
    pos_t  wp1;
    byte_t gc1;
    r.failed = fail;
    r.wp     = wp;
    r.cp     = cp;
    r.gc     = gc;
    r.n_wr   = 2'd0;
    r.a_addr = cp;
    r.a_val  = gc;
    r.b_addr = cp;
    wp1 = wp + pos_t'(1);
    gc1 = gc + byte_t'(1);
    if (!fail) begin
      if (wp >= {1'b0, cap}) begin
        r.failed = 1'b1;
      end else if (b == DELIM) begin
        r.n_wr = 2'd1;
        r.cp   = wp[WORD_W-1:0];
        r.wp   = wp1;
        r.gc   = byte_t'(1);
      end else begin
        r.n_wr   = 2'd1;
        r.a_addr = wp[WORD_W-1:0];
        r.a_val  = b;
        r.wp     = wp1;
        r.gc     = gc1;
        if (gc1 == FULL_CODE) begin
          if (cp >= cap) begin
            r.failed = 1'b1;
          end else begin
            r.n_wr = 2'd2;
            r.cp   = wp1[WORD_W-1:0];
            r.wp   = wp + pos_t'(2);
            r.gc   = byte_t'(1);
          end
        end
      end
    end
    return r;
  endfunction

  // Plain buffer write result
  function automatic result_t wr_result(input word_t addr, input byte_t val);
    result_t r;
    r = '0;
    r.write_en  = 1'b1;
    r.out_addr  = addr;
    r.out_value = val;
    return r;
  endfunction

endpackage

[hdl/cfe_in_if.sv]
// Input channel of the frame encoder: one payload byte per transfer.
// Depends on cfe_pkg.
`timescale 1ns / 1ps

interface cfe_in_if;
  logic           valid;
  logic           ready;
  cfe_pkg::byte_t data_byte;
  logic           last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

[hdl/cfe_out_if.sv]
// Result channel of the frame encoder: one buffer write or frame status per
// transfer. Depends on cfe_pkg.
`timescale 1ns / 1ps

interface cfe_out_if;
  logic           valid;
  logic           ready;
  logic           write_en;
  cfe_pkg::word_t out_addr;
  cfe_pkg::byte_t out_value;
  logic           frame_end;
  logic           frame_ok;
  cfe_pkg::word_t frame_length;
  logic           run_last;

  modport source (output valid, write_en, out_addr, out_value, frame_end, frame_ok,
                  frame_length, run_last, input ready);
  modport sink   (input valid, write_en, out_addr, out_value, frame_end, frame_ok,
                  frame_length, run_last, output ready);
endinterface

[hdl/crc16_cobs_frame_encoder.sv]
// Top level of the CRC16 / COBS frame encoder: front, record queue, back.
// Depends on cfe_pkg, cfe_in_if, cfe_out_if, cfe_front, cfe_fifo, cfe_back.
`timescale 1ns / 1ps

// Takes one payload byte per cycle while the record queue is not full,
// COBS encodes it with a CRC16-CCITT trailer (low byte first) and a zero
// delimiter, and gives buffer writes (address, byte) plus a frame status on
// the result that closes the frame. After the last byte of a frame the front
// sequencer steps through the CRC low byte, the CRC high byte and the closing
// code/delimiter before it takes input again, each step waiting while the
// queue is full. The back issues one result per cycle while the output is
// ready, so a byte that yields two writes (a full 254-byte group) gives two
// results; the record queue of QUEUE_DEPTH entries absorbs these bursts.
// Write configuration only while the encoder is idle.
module crc16_cobs_frame_encoder #(
  parameter int ADDR_WIDTH  = cfe_pkg::ADDR_WIDTH_DEF,
  parameter int QUEUE_DEPTH = cfe_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  cfe_in_if.sink            in_ch,
  cfe_out_if.source         out_ch,
  input  logic              cfg_we,
  input  cfe_pkg::cfg_idx_t cfg_index,
  input  cfe_pkg::word_t    cfg_wdata
);
  import cfe_pkg::*;

  logic q_full, q_push, q_pop, q_empty;
  rec_t q_rec, q_head;

  // Accept bytes and build records
  cfe_front #(
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_rec     (q_rec)
  );

  // Queue records between the two sides
  cfe_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_rec (q_rec),
    .full     (q_full),
    .pop      (q_pop),
    .head_rec (q_head),
    .empty    (q_empty)
  );

  // Issue one result per transfer
  cfe_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_rec (q_head),
    .empty    (q_empty),
    .pop      (q_pop),
    .out_ch   (out_ch)
  );

endmodule

[hdl/cfe_front.sv]
// Front of the frame encoder: takes payload bytes, keeps CRC and COBS state,
// and pushes result records into the queue. Depends on cfe_pkg, cfe_in_if.
`timescale 1ns / 1ps

module cfe_front #(
  parameter int ADDR_WIDTH = cfe_pkg::ADDR_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  cfe_in_if.sink            in_ch,
  input  logic              cfg_we,
  input  cfe_pkg::cfg_idx_t cfg_index,
  input  cfe_pkg::word_t    cfg_wdata,
  input  logic              q_full,
  output logic              q_push,
  output cfe_pkg::rec_t     q_rec
);
  import cfe_pkg::*;

  localparam word_t AddrMask = (ADDR_WIDTH >= WORD_W) ? {WORD_W{1'b1}} :
                               word_t'((64'd1 << ADDR_WIDTH) - 64'd1);

  front_state_t state_r, state_nxt;
  word_t        crc_r, crc_nxt;
  pos_t         wp_r, wp_nxt;
  word_t        cp_r, cp_nxt;
  byte_t        gc_r, gc_nxt;
  word_t        pc_r, pc_nxt;
  logic         failed_r, failed_nxt;
  word_t        cap_r, limit_r;

  logic         feed_fail;
  byte_t        feed_byte;
  cobs_t        cobs;
  logic         over_limit;
  logic         close_fail;
  logic         in_xfer;

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CAP_RESET;
      limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OUT_CAPACITY:  cap_r   <= cfg_wdata;
        REG_PAYLOAD_LIMIT: limit_r <= cfg_wdata;
      endcase
    end
  end

  // Hold the frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_PAYLOAD;
      crc_r    <= CRC_INIT;
      wp_r     <= pos_t'(1);
      cp_r     <= '0;
      gc_r     <= byte_t'(1);
      pc_r     <= '0;
      failed_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      crc_r    <= crc_nxt;
      wp_r     <= wp_nxt;
      cp_r     <= cp_nxt;
      gc_r     <= gc_nxt;
      pc_r     <= pc_nxt;
      failed_r <= failed_nxt;
    end
  end

  function automatic byte_t data_byte_sel();
    byte_t b;
    unique case (state_r)
      ST_PAYLOAD: b = in_ch.data_byte;
      ST_CRC_LO:  b = crc_r[BYTE_W-1:0];
      ST_CRC_HI:  b = crc_r[WORD_W-1:BYTE_W];
      default:    b = DELIM;
    endcase
    return b;
  endfunction

  // Pick the byte fed to the COBS writer in this step, and whether the feed fails
  assign over_limit = ({1'b0, pc_r} + pos_t'(2)) > {1'b0, limit_r};
  always_comb begin
    feed_fail = failed_r;
    feed_byte = data_byte_sel();
    unique case (state_r)
      ST_PAYLOAD: feed_fail = failed_r | (pc_r >= limit_r);
      ST_CRC_LO:  feed_fail = failed_r | over_limit;
      ST_CRC_HI:  feed_fail = failed_r;
      ST_CLOSE:   feed_fail = 1'b1;
      default:    feed_fail = 1'b1;
    endcase
  end

  assign cobs       = cobs_feed(feed_fail, wp_r, cp_r, gc_r, feed_byte, cap_r);
  assign close_fail = failed_r | (cp_r >= cap_r) | (wp_r >= {1'b0, cap_r});
  assign in_xfer    = in_ch.valid && in_ch.ready;

  // Advance the sequencer and build the record for this step
  always_comb begin
    state_nxt  = state_r;
    crc_nxt    = crc_r;
    wp_nxt     = wp_r;
    cp_nxt     = cp_r;
    gc_nxt     = gc_r;
    pc_nxt     = pc_r;
    failed_nxt = failed_r;
    in_ch.ready = 1'b0;
    q_push     = 1'b0;
    q_rec      = '0;
    q_rec.a    = wr_result(cobs.a_addr & AddrMask, cobs.a_val);
    q_rec.b    = wr_result(cobs.b_addr & AddrMask, FULL_CODE);
    q_rec.two  = (cobs.n_wr == 2'd2);

    unique case (state_r)
      ST_PAYLOAD: begin
        in_ch.ready = !q_full;
        if (in_xfer) begin
          if (!feed_fail) begin
            pc_nxt  = pc_r + word_t'(1);
            crc_nxt = crc_byte(crc_r, in_ch.data_byte);
          end
          failed_nxt     = cobs.failed;
          wp_nxt         = cobs.wp;
          cp_nxt         = cobs.cp;
          gc_nxt         = cobs.gc;
          q_push         = (cobs.n_wr != 2'd0);
          q_rec.step_end = !in_ch.last_byte;
          if (in_ch.last_byte) begin
            state_nxt = ST_CRC_LO;
          end
        end
      end
      ST_CRC_LO, ST_CRC_HI: begin
        if (!q_full) begin
          failed_nxt = cobs.failed;
          wp_nxt     = cobs.wp;
          cp_nxt     = cobs.cp;
          gc_nxt     = cobs.gc;
          q_push     = (cobs.n_wr != 2'd0);
          state_nxt  = (state_r == ST_CRC_LO) ? ST_CRC_HI : ST_CLOSE;
        end
      end
      ST_CLOSE: begin
        q_rec.step_end = 1'b1;
        if (close_fail) begin
          q_rec.a           = '0;
          q_rec.a.frame_end = 1'b1;
          q_rec.two         = 1'b0;
        end else begin
          q_rec.a                = wr_result(cp_r & AddrMask, gc_r);
          q_rec.b                = wr_result(wp_r[WORD_W-1:0] & AddrMask, DELIM);
          q_rec.b.frame_end      = 1'b1;
          q_rec.b.frame_ok       = 1'b1;
          q_rec.b.frame_length   = wp_r[WORD_W-1:0] + word_t'(1);
          q_rec.two              = 1'b1;
        end
        if (!q_full) begin
          q_push     = 1'b1;
          state_nxt  = ST_PAYLOAD;
          crc_nxt    = CRC_INIT;
          wp_nxt     = pos_t'(1);
          cp_nxt     = '0;
          gc_nxt     = byte_t'(1);
          pc_nxt     = '0;
          failed_nxt = 1'b0;
        end
      end
      default: state_nxt = ST_PAYLOAD;
    endcase
  end

endmodule

[hdl/cfe_fifo.sv]
// Record queue between front and back of the frame encoder.
// Depends on cfe_pkg.
`timescale 1ns / 1ps

module cfe_fifo #(
  parameter int DEPTH = cfe_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  cfe_pkg::rec_t push_rec,
  output logic          full,
  input  logic          pop,
  output cfe_pkg::rec_t head_rec,
  output logic          empty
);
  import cfe_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  rec_t            mem_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full     = (cnt_r == CntW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_rec = mem_r[rd_ptr_r];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store records
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

[hdl/cfe_back.sv]
// Back of the frame encoder: splits queued records into single results on
// the output channel. Depends on cfe_pkg, cfe_out_if.
`timescale 1ns / 1ps

module cfe_back (
  input  logic          clk,
  input  logic          rst_n,
  input  cfe_pkg::rec_t head_rec,
  input  logic          empty,
  output logic          pop,
  cfe_out_if.source     out_ch
);
  import cfe_pkg::*;

  logic    half_r, half_nxt;
  result_t cur;
  logic    rec_done;
  logic    out_xfer;

  // Present the first or second result of the head record
  assign cur      = half_r ? head_rec.b : head_rec.a;
  assign rec_done = !head_rec.two || half_r;
  assign out_xfer = out_ch.valid && out_ch.ready;
  assign pop      = out_xfer && rec_done;

  assign out_ch.valid        = !empty;
  assign out_ch.write_en     = cur.write_en;
  assign out_ch.out_addr     = cur.out_addr;
  assign out_ch.out_value    = cur.out_value;
  assign out_ch.frame_end    = cur.frame_end;
  assign out_ch.frame_ok     = cur.frame_ok;
  assign out_ch.frame_length = cur.frame_length;
  assign out_ch.run_last     = rec_done && head_rec.step_end;

  // Step to the second result, or back to the first after a pop
  always_comb begin
    half_nxt = half_r;
    if (out_xfer) begin
      half_nxt = !rec_done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r <= 1'b0;
    end else begin
      half_r <= half_nxt;
    end
  end

endmodule
